FILE: hdl/ethp_pkg.sv
package ethp_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_BINS  = 128;
    localparam int DEF_TIME_BITS = 32;

    // port widths fixed by the word layouts
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int S_DATA_W  = 40;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 232;
    localparam int DUR_W     = 32;
    localparam int SEL_W     = 7;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_MINIMUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd2;

    // configuration reset values
    localparam logic [31:0] RST_BIN_MINIMUM = 32'd0;
    localparam logic [31:0] RST_BIN_WIDTH   = 32'd500;
    localparam logic [7:0]  RST_BINS_IN_USE = 8'd100;

    // operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_step;
        logic lookup;
        logic lookup_sel;
        logic update_rec;
        logic update_rd;
        logic sweep_step;
        logic out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
        logic sweep_last;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/execution_time_histogram_profiler.sv
// channel   direction  handshake           payload
// s_        in         s_tvalid/s_tready   s_tuser operation, s_tdata duration, bin_select
// m_        out        m_tvalid/m_tready   m_tdata statistics, bin_index, bin_hits
// cfg_      in         cfg_wr_en           cfg_index, cfg_wdata
//
// record word: accept, serial bin divide (one step per quotient bit), lookup,
//   update, output load; read word: accept, lookup, update, output load
// no-operation word: accept, output load; clear word: accept, sweep, output load
// after reset the bin memory is swept to zero over all MAX_BINS entries, no word taken
// a finished word waits in the output register; a new word is taken meanwhile,
// and the next result waits until that register is free
module execution_time_histogram_profiler #(
    parameter int MAX_BINS  = ethp_pkg::DEF_MAX_BINS,
    parameter int TIME_BITS = ethp_pkg::DEF_TIME_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ethp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ethp_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ethp_pkg::S_USER_W-1:0]    s_tuser,   // operation
    input  logic [ethp_pkg::S_DATA_W-1:0]    s_tdata,   // duration, bin_select, pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // run_total, time_total, square_total, longest_seen, bin_index, bin_hits, pad
    output logic [ethp_pkg::M_DATA_W-1:0]    m_tdata
);

    ethp_pkg::cmd_t cmd;
    ethp_pkg::sts_t sts;

    // sequencer
    ethp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // divider, statistics and bin memory
    ethp_datapath #(
        .MAX_BINS  (MAX_BINS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_duration   (s_tdata[31:0]),
        .in_bin_select (s_tdata[38:32]),
        .cmd           (cmd),
        .sts           (sts),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

FILE: hdl/ethp_ctrl.sv
module ethp_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ethp_pkg::S_USER_W-1:0]    s_tuser,
    input  ethp_pkg::sts_t                   sts,
    output ethp_pkg::cmd_t                   cmd
);

    typedef enum logic [2:0] {
        ST_RESET_SWEEP,
        ST_IDLE,
        ST_DIVIDE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_CLEAR_SWEEP,
        ST_FINISH
    } state_t;

    state_t          state_reg, state_next;
    ethp_pkg::op_t   op_reg, op_next;
    logic            ready_reg, ready_next;
    logic            accept;
    ethp_pkg::op_t   in_op;

    assign in_op    = ethp_pkg::op_t'(s_tuser);
    assign accept   = s_tvalid & ready_reg;
    assign s_tready = ready_reg;

    // command decode
    always_comb begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) & accept;
        cmd.div_step   = (state_reg == ST_DIVIDE);
        cmd.lookup     = (state_reg == ST_LOOKUP);
        cmd.lookup_sel = (state_reg == ST_LOOKUP) & (op_reg == ethp_pkg::OP_READ);
        cmd.update_rec = (state_reg == ST_UPDATE) & (op_reg == ethp_pkg::OP_RECORD);
        cmd.update_rd  = (state_reg == ST_UPDATE) & (op_reg == ethp_pkg::OP_READ);
        cmd.sweep_step = (state_reg == ST_RESET_SWEEP) | (state_reg == ST_CLEAR_SWEEP);
        cmd.out_load   = (state_reg == ST_FINISH) & sts.out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_RESET_SWEEP: begin
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    op_next = in_op;
                    unique case (in_op)
                        ethp_pkg::OP_RECORD: state_next = ST_DIVIDE;
                        ethp_pkg::OP_CLEAR:  state_next = ST_CLEAR_SWEEP;
                        ethp_pkg::OP_READ:   state_next = ST_LOOKUP;
                        default:             state_next = ST_FINISH;
                    endcase
                end
            end
            ST_DIVIDE: begin
                if (sts.div_last) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_FINISH;
            end
            ST_CLEAR_SWEEP: begin
                if (sts.sweep_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    // state and registered ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RESET_SWEEP;
            op_reg    <= ethp_pkg::OP_NOP;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ready_reg <= ready_next;
        end
    end

endmodule

FILE: hdl/ethp_datapath.sv
module ethp_datapath #(
    parameter int MAX_BINS  = ethp_pkg::DEF_MAX_BINS,
    parameter int TIME_BITS = ethp_pkg::DEF_TIME_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ethp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ethp_pkg::CFG_DAT_W-1:0]   cfg_wdata,
    input  logic [ethp_pkg::DUR_W-1:0]       in_duration,
    input  logic [ethp_pkg::SEL_W-1:0]       in_bin_select,
    input  ethp_pkg::cmd_t                   cmd,
    output ethp_pkg::sts_t                   sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ethp_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int IW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW  = $clog2(TIME_BITS);
    localparam int SQW = 2 * TIME_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // configuration registers
    logic [31:0] min_reg;
    logic [31:0] width_reg;
    logic [7:0]  bins_reg;

    // item and divider registers
    logic [TIME_BITS-1:0]           dur_reg;
    logic [TIME_BITS-1:0]           quo_reg;
    logic [31:0]                    rem_reg;
    logic [CW-1:0]                  div_cnt_reg;
    logic [SQW-1:0]                 sq_reg;
    logic [ethp_pkg::SEL_W-1:0]     sel_reg;
    logic [ethp_pkg::SEL_W-1:0]     idx_reg;
    logic [IW-1:0]                  addr_reg;
    logic                           sel_ok_reg;
    logic [ethp_pkg::CNT_W-1:0]     hits_reg;
    logic [IW-1:0]                  sweep_reg;

    // statistics
    logic [ethp_pkg::CNT_W-1:0]     run_reg;
    logic [ethp_pkg::SUM_W-1:0]     time_reg;
    logic [ethp_pkg::SUM_W-1:0]     square_reg;
    logic [ethp_pkg::DUR_W-1:0]     longest_reg;

    // bin memory
    logic [ethp_pkg::CNT_W-1:0]     bin_mem [MAX_BINS];
    logic [ethp_pkg::CNT_W-1:0]     rd_data_reg;

    logic                           out_valid_reg;
    logic [ethp_pkg::M_DATA_W-1:0]  out_data_reg;

    // combinational helpers
    logic [TIME_BITS-1:0]           dur_sat;
    logic [31:0]                    dur_sat32;
    logic [31:0]                    divisor;
    logic [32:0]                    trial;
    logic                           trial_ge;
    logic [32:0]                    trial_diff;
    logic [SQW-1:0]                 sq_next;
    logic [31:0]                    nbins_eff;
    logic [31:0]                    quo32;
    logic [31:0]                    bin32;
    logic [31:0]                    sel32;
    logic                           sel_ok;
    logic [IW-1:0]                  rd_addr;
    logic                           mem_we;
    logic [IW-1:0]                  wr_addr;
    logic [ethp_pkg::CNT_W-1:0]     wr_data;
    logic [ethp_pkg::CNT_W-1:0]     hits_inc;
    logic [ethp_pkg::SUM_W:0]       time_sum;
    logic [ethp_pkg::SUM_W:0]       square_sum;
    logic [ethp_pkg::SUM_W-1:0]     time_next;
    logic [ethp_pkg::SUM_W-1:0]     square_next;
    logic [ethp_pkg::CNT_W-1:0]     run_next;
    logic                           sweep_last;

    // duration clipped to the time range
    assign dur_sat   = (in_duration > 32'(TIME_MAX)) ? TIME_MAX
                                                     : in_duration[TIME_BITS-1:0];
    assign dur_sat32 = 32'(dur_sat);

    // one restoring divide step per cycle
    assign divisor    = (width_reg == 32'd0) ? 32'd1 : width_reg;
    assign trial      = {rem_reg, quo_reg[TIME_BITS-1]};
    assign trial_ge   = (trial >= {1'b0, divisor});
    assign trial_diff = trial - {1'b0, divisor};

    // square of the held duration, registered each cycle
    assign sq_next = dur_reg * dur_reg;

    // bin clamp to the bins in use
    assign nbins_eff = (bins_reg == 8'd0)               ? 32'd1 :
                       (32'(bins_reg) > 32'(MAX_BINS))  ? 32'(MAX_BINS) :
                                                          32'(bins_reg);
    assign quo32 = 32'(quo_reg);
    assign bin32 = (quo32 >= nbins_eff) ? (nbins_eff - 32'd1) : quo32;

    assign sel32   = 32'(sel_reg);
    assign sel_ok  = (sel32 < 32'(MAX_BINS));
    assign rd_addr = cmd.lookup_sel ? sel32[IW-1:0] : bin32[IW-1:0];

    // memory write select: clearing sweep or count write-back
    assign hits_inc = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
    assign mem_we   = cmd.sweep_step | cmd.update_rec;
    assign wr_addr  = cmd.sweep_step ? sweep_reg : addr_reg;
    assign wr_data  = cmd.sweep_step ? '0 : hits_inc;

    assign sweep_last = (sweep_reg == IW'(MAX_BINS - 1));

    // saturating statistics
    assign run_next    = (run_reg == '1) ? run_reg : run_reg + 1'b1;
    assign time_sum    = {1'b0, time_reg} + 65'(dur_reg);
    assign square_sum  = {1'b0, square_reg} + 65'(sq_reg);
    assign time_next   = time_sum[ethp_pkg::SUM_W]   ? '1 : time_sum[ethp_pkg::SUM_W-1:0];
    assign square_next = square_sum[ethp_pkg::SUM_W] ? '1
                                                      : square_sum[ethp_pkg::SUM_W-1:0];

    assign sts.div_last   = (div_cnt_reg == CW'(TIME_BITS - 1));
    assign sts.sweep_last = sweep_last;
    assign sts.out_free   = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= ethp_pkg::RST_BIN_MINIMUM;
            width_reg <= ethp_pkg::RST_BIN_WIDTH;
            bins_reg  <= ethp_pkg::RST_BINS_IN_USE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ethp_pkg::CFG_BIN_MINIMUM: min_reg   <= cfg_wdata;
                ethp_pkg::CFG_BIN_WIDTH:   width_reg <= cfg_wdata;
                ethp_pkg::CFG_BINS_IN_USE: bins_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // item, divider and lookup registers
    always_ff @(posedge aclk) begin
        sq_reg <= sq_next;
        if (cmd.load) begin
            dur_reg     <= dur_sat;
            quo_reg     <= (dur_sat32 >= min_reg) ? TIME_BITS'(dur_sat32 - min_reg) : '0;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            sel_reg     <= in_bin_select;
            idx_reg     <= '0;
            hits_reg    <= '0;
        end
        if (cmd.div_step) begin
            rem_reg     <= trial_ge ? trial_diff[31:0] : trial[31:0];
            quo_reg     <= {quo_reg[TIME_BITS-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.lookup) begin
            idx_reg    <= cmd.lookup_sel ? sel_reg : bin32[ethp_pkg::SEL_W-1:0];
            addr_reg   <= rd_addr;
            sel_ok_reg <= cmd.lookup_sel ? sel_ok : 1'b1;
        end
        if (cmd.update_rec) begin
            hits_reg <= hits_inc;
        end
        if (cmd.update_rd) begin
            hits_reg <= sel_ok_reg ? rd_data_reg : '0;
        end
    end

    // bin memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bin_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bin_mem[rd_addr];
    end

    // statistics and sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            time_reg    <= '0;
            square_reg  <= '0;
            longest_reg <= '0;
            sweep_reg   <= '0;
        end else if (cmd.sweep_step) begin
            run_reg     <= '0;
            time_reg    <= '0;
            square_reg  <= '0;
            longest_reg <= '0;
            sweep_reg   <= sweep_last ? '0 : sweep_reg + 1'b1;
        end else if (cmd.update_rec) begin
            run_reg    <= run_next;
            time_reg   <= time_next;
            square_reg <= square_next;
            if (32'(dur_reg) > longest_reg) begin
                longest_reg <= 32'(dur_reg);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_data_reg <= {1'b0, hits_reg, idx_reg, longest_reg,
                             square_reg, time_reg, run_reg};
        end
    end

endmodule

FILE: tb/sv/execution_time_histogram_profiler_tb.sv
`timescale 1ns / 100ps

module execution_time_histogram_profiler_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int BIN_SLOTS   = ethp_pkg::DEF_MAX_BINS;

    // result word fields, run_total in the lowest bits
    typedef struct packed {
        logic [31:0] bin_hits;
        logic [6:0]  bin_index;
        logic [31:0] longest;
        logic [63:0] square_sum;
        logic [63:0] time_sum;
        logic [31:0] runs;
    } profile_result_t;

    // predicts the profiler statistics and holds the results still owed
    class profile_scoreboard;
        logic [31:0] bin_min;
        logic [31:0] bin_wid;
        logic [7:0]  bins_used;
        logic [31:0] runs;
        logic [63:0] time_sum;
        logic [63:0] square_sum;
        logic [31:0] longest;
        logic [31:0] counts [BIN_SLOTS];
        profile_result_t owed_results [$];
        int errors, checked, records, clears, reads, nops;

        function new();
            bin_min   = ethp_pkg::RST_BIN_MINIMUM;
            bin_wid   = ethp_pkg::RST_BIN_WIDTH;
            bins_used = ethp_pkg::RST_BINS_IN_USE;
            errors = 0; checked = 0; records = 0; clears = 0; reads = 0; nops = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            runs = '0;
            time_sum = '0;
            square_sum = '0;
            longest = '0;
            foreach (counts[i]) counts[i] = '0;
        endfunction

        function void set_reg(logic [ethp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                ethp_pkg::CFG_BIN_MINIMUM: bin_min = val;
                ethp_pkg::CFG_BIN_WIDTH:   bin_wid = val;
                ethp_pkg::CFG_BINS_IN_USE: bins_used = val[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_bins();
            if (bins_used == 0) return 1;
            if (bins_used > BIN_SLOTS) return BIN_SLOTS;
            return bins_used;
        endfunction

        function logic [31:0] eff_width();
            return (bin_wid == 0) ? 32'd1 : bin_wid;
        endfunction

        // linear bin, clamped to the first and last bin in use
        function logic [6:0] bin_for(logic [31:0] d);
            logic [31:0] q;
            if (d < bin_min) return '0;
            q = (d - bin_min) / eff_width();
            if (q >= eff_bins()) q = eff_bins() - 1;
            return q[6:0];
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // accepted input word: update the statistics and queue the result
        function void note_word(ethp_pkg::op_t op, logic [31:0] dur, logic [6:0] sel);
            profile_result_t res;
            logic [64:0] sum;
            logic [6:0] slot;
            res = '0;
            case (op)
                ethp_pkg::OP_RECORD: begin
                    if (runs != '1) runs = runs + 1;
                    sum = {1'b0, time_sum} + dur;
                    time_sum = sum[64] ? '1 : sum[63:0];
                    sum = {1'b0, square_sum} + 64'(dur) * 64'(dur);
                    square_sum = sum[64] ? '1 : sum[63:0];
                    if (dur > longest) longest = dur;
                    slot = bin_for(dur);
                    if (counts[slot] != '1) counts[slot] = counts[slot] + 1;
                    res.bin_index = slot;
                    res.bin_hits = counts[slot];
                    records++;
                end
                ethp_pkg::OP_CLEAR: begin
                    clear_stats();
                    clears++;
                end
                ethp_pkg::OP_READ: begin
                    res.bin_index = sel;
                    res.bin_hits = counts[sel];
                    reads++;
                end
                ethp_pkg::OP_NOP: nops++;
                default: ;
            endcase
            res.runs = runs;
            res.time_sum = time_sum;
            res.square_sum = square_sum;
            res.longest = longest;
            owed_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // accepted result word against the oldest owed result
        function void check_word(logic [ethp_pkg::M_DATA_W-1:0] word);
            profile_result_t got, want;
            got = word[$bits(profile_result_t)-1:0];
            if (owed_results.size() == 0) begin
                $error("result word arrived with nothing owed");
                errors++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            compare_field("run_total", want.runs, got.runs);
            compare_field("time_total", want.time_sum, got.time_sum);
            compare_field("square_total", want.square_sum, got.square_sum);
            compare_field("longest_seen", want.longest, got.longest);
            compare_field("bin_index", want.bin_index, got.bin_index);
            compare_field("bin_hits", want.bin_hits, got.bin_hits);
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [ethp_pkg::CFG_IDX_W-1:0] cfg_index = ethp_pkg::CFG_BIN_MINIMUM;
    logic [ethp_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ethp_pkg::S_USER_W-1:0]  s_tuser = ethp_pkg::OP_NOP;   // operation
    logic [ethp_pkg::S_DATA_W-1:0]  s_tdata = '0;       // duration, bin_select, pad
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // run_total, time_total, square_total, longest_seen, bin_index, bin_hits, pad
    logic [ethp_pkg::M_DATA_W-1:0]  m_tdata;

    profile_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int setting_count = 0;

    execution_time_histogram_profiler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    task automatic write_reg(input logic [ethp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_setting(input logic [31:0] lo, input logic [31:0] wid,
                                input logic [31:0] cnt);
        write_reg(ethp_pkg::CFG_BIN_MINIMUM, lo);
        write_reg(ethp_pkg::CFG_BIN_WIDTH, wid);
        write_reg(ethp_pkg::CFG_BINS_IN_USE, cnt);
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    // offer one word, with random idle cycles ahead of it
    task automatic send_word(input ethp_pkg::op_t op, input logic [31:0] dur,
                             input logic [6:0] sel);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, sel, dur};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, dur, sel);
    endtask

    // sender pauses until every owed result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // mostly records spread over the bins in use, some reads, clears and no-ops
    task automatic random_word();
        int unsigned pick;
        logic [63:0] span;
        logic [31:0] dur;
        logic [6:0] sel;
        ethp_pkg::op_t op;
        pick = $urandom_range(0, 99);
        op = (pick < 68) ? ethp_pkg::OP_RECORD :
             (pick < 72) ? ethp_pkg::OP_CLEAR  :
             (pick < 94) ? ethp_pkg::OP_READ   : ethp_pkg::OP_NOP;
        span = 64'(sb.eff_width()) * sb.eff_bins();
        span = span + span / 8 + 1;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            dur = $urandom();
        end else if (pick < 16) begin
            case ($urandom_range(0, 3))
                0: dur = '0;
                1: dur = '1;
                2: dur = sb.bin_min - 1;
                default: dur = sb.bin_min;
            endcase
        end else begin
            dur = sb.bin_min + $urandom_range(0, span[31:0]);
        end
        if ($urandom_range(0, 3) != 0) sel = 7'($urandom_range(0, sb.eff_bins() - 1));
        else sel = 7'($urandom_range(0, 127));
        send_word(op, dur, sel);
    endtask

    // bin settings for the random part, extremes included
    task automatic random_setting(input int kind);
        case (kind)
            0: load_setting($urandom_range(0, 5000), $urandom_range(1, 1000),
                            $urandom_range(1, 128));
            1: load_setting(32'd0, 32'd1, 32'd128);
            2: load_setting($urandom_range(0, 100), 32'd0, 32'd0);
            3: load_setting($urandom(), 32'hFFFF_FFFF, 32'd255);
            4: load_setting(32'hFFFF_FFF0, 32'd3, 32'd64);
            default: load_setting($urandom(), $urandom(), $urandom());
        endcase
    endtask

    // stimulus
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values, written back explicitly
        load_setting(ethp_pkg::RST_BIN_MINIMUM, ethp_pkg::RST_BIN_WIDTH,
                     32'(ethp_pkg::RST_BINS_IN_USE));
        send_word(ethp_pkg::OP_NOP, '0, '0);
        send_word(ethp_pkg::OP_READ, '0, 7'd99);
        send_word(ethp_pkg::OP_RECORD, 32'd1234, '0);
        send_word(ethp_pkg::OP_RECORD, 32'd60000, '0);
        wait_drained();

        // below minimum, top of range, beyond range, square sum saturation
        load_setting(32'd100, 32'd10, 32'd8);
        send_word(ethp_pkg::OP_RECORD, 32'd0, '0);
        send_word(ethp_pkg::OP_RECORD, 32'd100, '0);
        send_word(ethp_pkg::OP_RECORD, 32'd179, '0);
        send_word(ethp_pkg::OP_RECORD, 32'd180, '0);
        send_word(ethp_pkg::OP_RECORD, 32'hFFFF_FFFF, '0);
        send_word(ethp_pkg::OP_RECORD, 32'hFFFF_FFFF, '0);
        // unused bins keep their counts, never-hit bins read zero
        send_word(ethp_pkg::OP_READ, '0, 7'd7);
        send_word(ethp_pkg::OP_READ, '0, 7'd99);
        send_word(ethp_pkg::OP_READ, '0, 7'd127);
        send_word(ethp_pkg::OP_RECORD, 32'h5555_5555, 7'h55);
        send_word(ethp_pkg::OP_RECORD, 32'hAAAA_AAAA, 7'h2A);
        send_word(ethp_pkg::OP_READ, 32'hAAAA_AAAA, 7'h55);
        send_word(ethp_pkg::OP_READ, 32'h5555_5555, 7'h2A);
        send_word(ethp_pkg::OP_NOP, 32'hFFFF_FFFF, 7'h7F);
        send_word(ethp_pkg::OP_CLEAR, 32'hFFFF_FFFF, 7'h7F);
        send_word(ethp_pkg::OP_READ, '0, 7'd7);
        wait_drained();

        // zero width and zero bins fall back to one
        load_setting(32'd100, 32'd0, 32'd0);
        send_word(ethp_pkg::OP_RECORD, 32'd5, '0);
        send_word(ethp_pkg::OP_RECORD, 32'd4000, '0);
        wait_drained();

        // widest bins, too many bins in use
        load_setting(32'd0, 32'hFFFF_FFFF, 32'd255);
        send_word(ethp_pkg::OP_RECORD, 32'hFFFF_FFFE, '0);
        send_word(ethp_pkg::OP_RECORD, 32'hFFFF_FFFF, '0);
        wait_drained();
        load_setting(32'hFFFF_FFFF, 32'd1, 32'd200);
        send_word(ethp_pkg::OP_RECORD, 32'd0, '0);
        send_word(ethp_pkg::OP_RECORD, 32'hFFFF_FFFF, '0);
        wait_drained();

        // random part in three idling patterns
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 87 : 0;
            recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 15 : 0;
            for (int s = 0; s < 4; s++) begin
                wait_drained();
                random_setting((phase * 4 + s) % 6);
                if ($urandom_range(0, 3) != 0) send_word(ethp_pkg::OP_CLEAR, $urandom(), '0);
                repeat (100) random_word();
            end
        end

        // long receiver hold-off while words keep coming, so the input stalls
        wait_drained();
        hold_request = 600;
        repeat (30) random_word();

        wait_drained();
        repeat (200) @(posedge aclk);

        $display("Run covered %0d records, %0d clears, %0d reads and %0d no-op words",
                 sb.records, sb.clears, sb.reads, sb.nops);
        $display("over %0d bin settings; %0d result words compared, %0d errors",
                 setting_count, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/ethp_pkg.sv
hdl/ethp_ctrl.sv
hdl/ethp_datapath.sv
hdl/execution_time_histogram_profiler.sv
tb/sv/execution_time_histogram_profiler_tb.sv
